// ===== design/lsc_pkg.sv =====
// Shared types and codes for the line segment window clipper.
// No dependencies.
`default_nettype none
package lsc_pkg;

    typedef struct packed {
        logic pzero;
        logic qneg;
        logic pneg;
    } edge_flags_t;

    typedef enum logic [1:0] {
        CFG_LEFT   = 2'd0,
        CFG_RIGHT  = 2'd1,
        CFG_BOTTOM = 2'd2,
        CFG_TOP    = 2'd3
    } cfg_index_t;

    localparam int CFG_INDEX_BITS = 2;

endpackage
`default_nettype wire

// ===== design/lsc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side-data lane.
// Depends on lsc_pkg.
`default_nettype none
module lsc_div import lsc_pkg::*; #(
    parameter int MAG_W  = 13,
    parameter int FRAC_W = 16,
    parameter int SIDE_W = 3
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [MAG_W-1:0]  in_p_mag,
    input  wire logic [MAG_W-1:0]  in_q_mag,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [FRAC_W:0]        out_quo,
    output logic                   out_sat,
    output logic [SIDE_W-1:0]      out_side
);

    localparam int NS = FRAC_W + 2;

    logic              valid_reg [NS];
    logic [MAG_W:0]    rem_reg   [NS];
    logic [MAG_W-1:0]  dvs_reg   [NS];
    logic [FRAC_W:0]   quo_reg   [NS];
    logic              sat_reg   [NS];
    logic [SIDE_W-1:0] side_reg  [NS];

    logic              valid_next [NS];
    logic [MAG_W:0]    rem_next   [NS];
    logic [MAG_W-1:0]  dvs_next   [NS];
    logic [FRAC_W:0]   quo_next   [NS];
    logic              sat_next   [NS];
    logic [SIDE_W-1:0] side_next  [NS];

    assign valid_next[0] = in_valid;
    assign rem_next[0]   = {1'b0, in_q_mag};
    assign dvs_next[0]   = in_p_mag;
    assign quo_next[0]   = '0;
    // quotient would need more than FRAC_W+1 bits: ratio is 2.0 or above
    assign sat_next[0]   = {1'b0, in_q_mag} >= {in_p_mag, 1'b0};
    assign side_next[0]  = in_side;

    for (genvar s = 1; s < NS; s++) begin : g_step
        logic           ge;
        logic [MAG_W:0] diff;
        assign ge   = rem_reg[s-1] >= {1'b0, dvs_reg[s-1]};
        assign diff = ge ? rem_reg[s-1] - {1'b0, dvs_reg[s-1]} : rem_reg[s-1];
        assign valid_next[s] = valid_reg[s-1];
        assign rem_next[s]   = {diff[MAG_W-1:0], 1'b0};
        assign dvs_next[s]   = dvs_reg[s-1];
        assign quo_next[s]   = {quo_reg[s-1][FRAC_W-1:0], ge};
        assign sat_next[s]   = sat_reg[s-1];
        assign side_next[s]  = side_reg[s-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NS; s++) valid_reg[s] <= 1'b0;
        end else if (en) begin
            for (int s = 0; s < NS; s++) valid_reg[s] <= valid_next[s];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < NS; s++) begin
                rem_reg[s]  <= rem_next[s];
                dvs_reg[s]  <= dvs_next[s];
                quo_reg[s]  <= quo_next[s];
                sat_reg[s]  <= sat_next[s];
                side_reg[s] <= side_next[s];
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_quo   = quo_reg[NS-1];
    assign out_sat   = sat_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule
`default_nettype wire

// ===== design/lsc_edge_pair.sv =====
// One register stage applying two boundary tests to the entry/exit parameters.
// Depends on lsc_pkg.
`default_nettype none
module lsc_edge_pair import lsc_pkg::*; #(
    parameter int FRAC_W = 16,
    parameter int SIDE_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic              in_ok,
    input  wire logic [FRAC_W:0]   in_t1,
    input  wire logic [FRAC_W:0]   in_t2,
    input  wire edge_flags_t       in_flags_a,
    input  wire edge_flags_t       in_flags_b,
    input  wire logic [FRAC_W:0]   in_quo_a,
    input  wire logic [FRAC_W:0]   in_quo_b,
    input  wire logic              in_sat_a,
    input  wire logic              in_sat_b,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic                   out_ok,
    output logic [FRAC_W:0]        out_t1,
    output logic [FRAC_W:0]        out_t2,
    output logic [SIDE_W-1:0]      out_side
);

    localparam logic [FRAC_W:0] R_SAT = {1'b1, {(FRAC_W-1){1'b0}}, 1'b1};

    logic              valid_reg;
    logic              ok_reg;
    logic [FRAC_W:0]   t1_reg;
    logic [FRAC_W:0]   t2_reg;
    logic [SIDE_W-1:0] side_reg;

    logic              ok_next;
    logic [FRAC_W:0]   t1_next;
    logic [FRAC_W:0]   t2_next;

    edge_flags_t       fl   [2];
    logic [FRAC_W:0]   quo  [2];
    logic              sat  [2];

    assign fl[0]  = in_flags_a;
    assign fl[1]  = in_flags_b;
    assign quo[0] = in_quo_a;
    assign quo[1] = in_quo_b;
    assign sat[0] = in_sat_a;
    assign sat[1] = in_sat_b;

    always_comb begin
        logic [FRAC_W:0]          mag;
        logic signed [FRAC_W+1:0] r;
        ok_next = in_ok;
        t1_next = in_t1;
        t2_next = in_t2;
        for (int e = 0; e < 2; e++) begin
            mag = sat[e] ? R_SAT : quo[e];
            r   = (fl[e].qneg ^ fl[e].pneg) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            if (fl[e].pzero) begin
                if (fl[e].qneg) ok_next = 1'b0;
            end else if (fl[e].pneg) begin
                if (r > $signed({1'b0, t2_next})) ok_next = 1'b0;
                else if (r > $signed({1'b0, t1_next})) t1_next = r[FRAC_W:0];
            end else begin
                if (r < $signed({1'b0, t1_next})) ok_next = 1'b0;
                else if (r < $signed({1'b0, t2_next})) t2_next = r[FRAC_W:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ok_reg   <= ok_next;
            t1_reg   <= t1_next;
            t2_reg   <= t2_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_ok    = ok_reg;
    assign out_t1    = t1_reg;
    assign out_t2    = t2_reg;
    assign out_side  = side_reg;

endmodule
`default_nettype wire

// ===== design/lsc_move.sv =====
// Two-stage endpoint interpolation: multiply, then add and truncate toward zero.
// Depends on lsc_pkg.
`default_nettype none
module lsc_move import lsc_pkg::*; #(
    parameter int COORD_W = 12,
    parameter int FRAC_W  = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic                      in_ok,
    input  wire logic [FRAC_W:0]           in_t1,
    input  wire logic [FRAC_W:0]           in_t2,
    input  wire logic signed [COORD_W-1:0] in_x1,
    input  wire logic signed [COORD_W-1:0] in_y1,
    input  wire logic signed [COORD_W:0]   in_dx,
    input  wire logic signed [COORD_W:0]   in_dy,
    output logic                           out_valid,
    output logic                           out_visible,
    output logic signed [COORD_W-1:0]      out_sx,
    output logic signed [COORD_W-1:0]      out_sy,
    output logic signed [COORD_W-1:0]      out_ex,
    output logic signed [COORD_W-1:0]      out_ey
);

    localparam int PW = FRAC_W + COORD_W + 3;
    localparam int SW = FRAC_W + COORD_W + 4;
    localparam logic [FRAC_W:0] T_ONE = {1'b1, {FRAC_W{1'b0}}};

    logic                     valid1_reg, ok1_reg, mv_end_reg, mv_start_reg;
    logic signed [COORD_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [PW-1:0]     pex_reg, pey_reg, psx_reg, psy_reg;

    logic                     valid2_reg, vis_reg;
    logic signed [COORD_W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;

    function automatic logic signed [COORD_W-1:0] interp(
        input logic signed [COORD_W-1:0] c,
        input logic signed [PW-1:0]      prod
    );
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] adj;
        sum = (SW'(c) <<< FRAC_W) + SW'(prod);
        adj = sum[SW-1] ? sum + $signed(SW'({FRAC_W{1'b1}})) : sum;
        return adj[FRAC_W+COORD_W-1:FRAC_W];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ok1_reg      <= in_ok;
            mv_end_reg   <= in_t2 != T_ONE;
            mv_start_reg <= in_t1 != '0;
            x1_reg       <= in_x1;
            y1_reg       <= in_y1;
            x2_reg       <= in_x1 + in_dx[COORD_W-1:0];
            y2_reg       <= in_y1 + in_dy[COORD_W-1:0];
            pex_reg      <= $signed({1'b0, in_t2}) * in_dx;
            pey_reg      <= $signed({1'b0, in_t2}) * in_dy;
            psx_reg      <= $signed({1'b0, in_t1}) * in_dx;
            psy_reg      <= $signed({1'b0, in_t1}) * in_dy;

            vis_reg <= ok1_reg;
            if (!ok1_reg) begin
                sx_reg <= '0;
                sy_reg <= '0;
                ex_reg <= '0;
                ey_reg <= '0;
            end else begin
                sx_reg <= mv_start_reg ? interp(x1_reg, psx_reg) : x1_reg;
                sy_reg <= mv_start_reg ? interp(y1_reg, psy_reg) : y1_reg;
                ex_reg <= mv_end_reg ? interp(x1_reg, pex_reg) : x2_reg;
                ey_reg <= mv_end_reg ? interp(y1_reg, pey_reg) : y2_reg;
            end
        end
    end

    assign out_valid   = valid2_reg;
    assign out_visible = vis_reg;
    assign out_sx      = sx_reg;
    assign out_sy      = sy_reg;
    assign out_ex      = ex_reg;
    assign out_ey      = ey_reg;

endmodule
`default_nettype wire

// ===== design/line_segment_window_clip.sv =====
// Liang-Barsky segment clipper, top level.
// Depends on lsc_pkg, lsc_div, lsc_edge_pair, lsc_move.
//
// Usage:
//   Window edges are written through cfg_we/cfg_index/cfg_data (left, right,
//   bottom, top) while no segment is in flight. Segments arrive on the s_
//   valid/ready channel, one request per endpoint pair; each yields exactly one
//   result request on the m_ channel: a visible flag and the clipped endpoints,
//   all zero when the segment is rejected.
//   Throughput: one segment per cycle while m_ready does not stall the
//   pipeline. The pipeline is the bit-per-stage divider pipeline (four
//   lanes, T_FRAC_BITS + 2 stages) plus input, two test and two interpolation
//   stages.
//   Reset (aresetn low, synchronous) empties the pipeline and loads the window
//   50, 300, 250, 500.
//   When m_ready is low with a result held, the whole pipeline freezes and
//   s_ready drops; nothing is lost or repeated.
`default_nettype none
module line_segment_window_clip import lsc_pkg::*; #(
    parameter int COORD_BITS  = 12,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [COORD_BITS-1:0]         cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [COORD_BITS-1:0]  s_start_x,
    input  wire logic signed [COORD_BITS-1:0]  s_start_y,
    input  wire logic signed [COORD_BITS-1:0]  s_end_x,
    input  wire logic signed [COORD_BITS-1:0]  s_end_y,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_visible,
    output logic signed [COORD_BITS-1:0]       m_clip_start_x,
    output logic signed [COORD_BITS-1:0]       m_clip_start_y,
    output logic signed [COORD_BITS-1:0]       m_clip_end_x,
    output logic signed [COORD_BITS-1:0]       m_clip_end_y
);

    localparam int C     = COORD_BITS;
    localparam int F     = T_FRAC_BITS;
    localparam int FL_W  = $bits(edge_flags_t);
    localparam int CRD_W = 4 * C + 2;
    localparam int S0_W  = CRD_W + FL_W;
    localparam int S1_W  = CRD_W + 2 * FL_W + 2 * (F + 1) + 2;
    localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};

    logic en;

    // window registers
    logic signed [C-1:0] left_reg, right_reg, bottom_reg, top_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= C'(50);
            right_reg  <= C'(300);
            bottom_reg <= C'(250);
            top_reg    <= C'(500);
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LEFT:   left_reg   <= cfg_data;
                CFG_RIGHT:  right_reg  <= cfg_data;
                CFG_BOTTOM: bottom_reg <= cfg_data;
                CFG_TOP:    top_reg    <= cfg_data;
                default:    ;
            endcase
        end
    end

    // input stage: deltas, magnitudes and sign flags of the four tests
    logic signed [C:0] dx, dy, dmx, dmy;
    logic signed [C:0] q_next [4];
    logic [C:0]        qmag_next [4];
    edge_flags_t       fl_next [4];

    assign dx  = {s_end_x[C-1], s_end_x} - {s_start_x[C-1], s_start_x};
    assign dy  = {s_end_y[C-1], s_end_y} - {s_start_y[C-1], s_start_y};
    assign dmx = dx[C] ? -dx : dx;
    assign dmy = dy[C] ? -dy : dy;

    assign q_next[0] = {s_start_x[C-1], s_start_x} - {left_reg[C-1], left_reg};
    assign q_next[1] = {right_reg[C-1], right_reg} - {s_start_x[C-1], s_start_x};
    assign q_next[2] = {s_start_y[C-1], s_start_y} - {bottom_reg[C-1], bottom_reg};
    assign q_next[3] = {top_reg[C-1], top_reg} - {s_start_y[C-1], s_start_y};

    for (genvar e = 0; e < 4; e++) begin : g_q
        assign qmag_next[e]    = q_next[e][C] ? -q_next[e] : q_next[e];
        assign fl_next[e].qneg = q_next[e][C];
    end

    assign fl_next[0].pzero = dx == '0;
    assign fl_next[0].pneg  = !dx[C] && (dx != '0);
    assign fl_next[1].pzero = dx == '0;
    assign fl_next[1].pneg  = dx[C];
    assign fl_next[2].pzero = dy == '0;
    assign fl_next[2].pneg  = !dy[C] && (dy != '0);
    assign fl_next[3].pzero = dy == '0;
    assign fl_next[3].pneg  = dy[C];

    logic              a_valid_reg;
    logic [C:0]        pmag_reg [4];
    logic [C:0]        qmag_reg [4];
    edge_flags_t       fl_reg   [4];
    logic [CRD_W-1:0]  crd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pmag_reg[0] <= dmx;
            pmag_reg[1] <= dmx;
            pmag_reg[2] <= dmy;
            pmag_reg[3] <= dmy;
            for (int e = 0; e < 4; e++) begin
                qmag_reg[e] <= qmag_next[e];
                fl_reg[e]   <= fl_next[e];
            end
            crd_reg <= {s_start_x, s_start_y, dx, dy};
        end
    end

    // dividers
    logic        d_valid [4];
    logic [F:0]  d_quo   [4];
    logic        d_sat   [4];
    logic [S0_W-1:0] side0;
    edge_flags_t d_fl    [4];
    logic [CRD_W-1:0] d_crd;

    lsc_div #(.MAG_W(C + 1), .FRAC_W(F), .SIDE_W(S0_W)) u_div0 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(a_valid_reg),
        .in_p_mag(pmag_reg[0]), .in_q_mag(qmag_reg[0]), .in_side({crd_reg, fl_reg[0]}),
        .out_valid(d_valid[0]), .out_quo(d_quo[0]), .out_sat(d_sat[0]), .out_side(side0)
    );
    assign {d_crd, d_fl[0]} = side0;

    for (genvar e = 1; e < 4; e++) begin : g_div
        lsc_div #(.MAG_W(C + 1), .FRAC_W(F), .SIDE_W(FL_W)) u_div (
            .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(a_valid_reg),
            .in_p_mag(pmag_reg[e]), .in_q_mag(qmag_reg[e]), .in_side(fl_reg[e]),
            .out_valid(d_valid[e]), .out_quo(d_quo[e]), .out_sat(d_sat[e]),
            .out_side(d_fl[e])
        );
    end

    // boundary tests: left/right, then bottom/top
    logic             p1_valid, p1_ok;
    logic [F:0]       p1_t1, p1_t2;
    logic [S1_W-1:0]  p1_side;
    logic [CRD_W-1:0] p1_crd;
    edge_flags_t      p1_fl2, p1_fl3;
    logic [F:0]       p1_quo2, p1_quo3;
    logic             p1_sat2, p1_sat3;

    lsc_edge_pair #(.FRAC_W(F), .SIDE_W(S1_W)) u_pair_x (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(d_valid[0]),
        .in_ok(1'b1), .in_t1('0), .in_t2(T_ONE),
        .in_flags_a(d_fl[0]), .in_flags_b(d_fl[1]),
        .in_quo_a(d_quo[0]), .in_quo_b(d_quo[1]),
        .in_sat_a(d_sat[0]), .in_sat_b(d_sat[1]),
        .in_side({d_crd, d_fl[2], d_fl[3], d_quo[2], d_quo[3], d_sat[2], d_sat[3]}),
        .out_valid(p1_valid), .out_ok(p1_ok), .out_t1(p1_t1), .out_t2(p1_t2),
        .out_side(p1_side)
    );
    assign {p1_crd, p1_fl2, p1_fl3, p1_quo2, p1_quo3, p1_sat2, p1_sat3} = p1_side;

    logic             p2_valid, p2_ok;
    logic [F:0]       p2_t1, p2_t2;
    logic [CRD_W-1:0] p2_crd;

    lsc_edge_pair #(.FRAC_W(F), .SIDE_W(CRD_W)) u_pair_y (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(p1_valid),
        .in_ok(p1_ok), .in_t1(p1_t1), .in_t2(p1_t2),
        .in_flags_a(p1_fl2), .in_flags_b(p1_fl3),
        .in_quo_a(p1_quo2), .in_quo_b(p1_quo3),
        .in_sat_a(p1_sat2), .in_sat_b(p1_sat3),
        .in_side(p1_crd),
        .out_valid(p2_valid), .out_ok(p2_ok), .out_t1(p2_t1), .out_t2(p2_t2),
        .out_side(p2_crd)
    );

    logic signed [C-1:0] m_x1, m_y1;
    logic signed [C:0]   m_dx, m_dy;
    assign {m_x1, m_y1, m_dx, m_dy} = p2_crd;

    lsc_move #(.COORD_W(C), .FRAC_W(F)) u_move (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(p2_valid),
        .in_ok(p2_ok), .in_t1(p2_t1), .in_t2(p2_t2),
        .in_x1(m_x1), .in_y1(m_y1), .in_dx(m_dx), .in_dy(m_dy),
        .out_valid(m_valid), .out_visible(m_visible),
        .out_sx(m_clip_start_x), .out_sy(m_clip_start_y),
        .out_ex(m_clip_end_x), .out_ey(m_clip_end_y)
    );

    assign en      = !m_valid || m_ready;
    assign s_ready = en && aresetn;

endmodule
`default_nettype wire

// ===== sim/tb_line_segment_window_clip.sv =====
// Testbench for line_segment_window_clip: Liang-Barsky clipping against a window.
// Drives segments with random bursts and result stalls, predicts each clip result.
// Depends on lsc_pkg and the line_segment_window_clip RTL.
`default_nettype none
module tb_line_segment_window_clip;
    import lsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 12;
    localparam int TF = 16;
    localparam longint T_ONE = 64'sd1 << TF;
    localparam int WATCHDOG = 20000;

    typedef struct {
        logic           visible;
        logic [CB-1:0]  sx, sy, ex, ey;
    } clip_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_LEFT;
    logic [CB-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [CB-1:0] s_start_x = '0, s_start_y = '0, s_end_x = '0, s_end_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_visible;
    logic signed [CB-1:0] m_clip_start_x, m_clip_start_y, m_clip_end_x, m_clip_end_y;

    line_segment_window_clip #(.COORD_BITS(CB), .T_FRAC_BITS(TF)) dut (.*);

    always #2 aclk = ~aclk;

    longint win_l = 50, win_r = 300, win_b = 250, win_t = 500;
    clip_t expected_clips[$];
    int errors = 0;
    int segs_sent = 0;
    int clips_seen = 0;
    int visible_seen = 0;
    int idle_cycles = 0;
    int rx_cycle = 0;
    bit hold_off = 1'b0;
    int gap_max = 3;

    function automatic bit edge_pass(longint p, longint q, ref longint t1, ref longint t2);
        longint r;
        if (p == 0) return q >= 0;
        r = (q * T_ONE) / p;
        if (p < 0) begin
            if (r > t2) return 1'b0;
            if (r > t1) t1 = r;
        end else begin
            if (r < t1) return 1'b0;
            if (r < t2) t2 = r;
        end
        return 1'b1;
    endfunction

    function automatic longint interp(longint c, longint t, longint d);
        return (c * T_ONE + t * d) / T_ONE;
    endfunction

    function automatic clip_t clip_segment(logic signed [CB-1:0] x1s, y1s, x2s, y2s);
        clip_t res;
        longint x1, y1, x2, y2, dx, dy, t1, t2, sx, sy, ex, ey;
        bit ok;
        x1 = x1s; y1 = y1s; x2 = x2s; y2 = y2s;
        dx = x2 - x1; dy = y2 - y1;
        t1 = 0; t2 = T_ONE;
        sx = x1; sy = y1; ex = x2; ey = y2;
        ok = edge_pass(-dx, x1 - win_l, t1, t2);
        if (ok) ok = edge_pass(dx, win_r - x1, t1, t2);
        if (ok) ok = edge_pass(-dy, y1 - win_b, t1, t2);
        if (ok) ok = edge_pass(dy, win_t - y1, t1, t2);
        res.visible = ok;
        if (!ok) begin
            res.sx = '0; res.sy = '0; res.ex = '0; res.ey = '0;
            return res;
        end
        if (t2 < T_ONE) begin
            ex = interp(x1, t2, dx);
            ey = interp(y1, t2, dy);
        end
        if (t1 > 0) begin
            sx = interp(x1, t1, dx);
            sy = interp(y1, t1, dy);
        end
        res.sx = sx[CB-1:0]; res.sy = sy[CB-1:0];
        res.ex = ex[CB-1:0]; res.ey = ey[CB-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // result checker and watchdog
    always @(posedge aclk) begin
        clip_t e;
        if (aresetn && m_valid && m_ready) begin
            clips_seen++;
            if (m_visible) visible_seen++;
            if (expected_clips.size() == 0) begin
                report_mismatch("unexpected result, visible", m_visible, 0);
            end else begin
                e = expected_clips.pop_front();
                if (m_visible !== e.visible) report_mismatch("visible", m_visible, e.visible);
                if (m_clip_start_x !== e.sx)
                    report_mismatch("clip_start_x", m_clip_start_x, $signed(e.sx));
                if (m_clip_start_y !== e.sy)
                    report_mismatch("clip_start_y", m_clip_start_y, $signed(e.sy));
                if (m_clip_end_x !== e.ex)
                    report_mismatch("clip_end_x", m_clip_end_x, $signed(e.ex));
                if (m_clip_end_y !== e.ey)
                    report_mismatch("clip_end_y", m_clip_end_y, $signed(e.ey));
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("timeout with %0d results pending", expected_clips.size());
            $display("line_segment_window_clip test failed");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        int r;
        r = $urandom_range(0, 15);
        rx_cycle++;
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= (r < 11) || ((rx_cycle % 200) < 60);
    end

    task automatic send_segment(logic signed [CB-1:0] x1, y1, x2, y2);
        s_start_x <= x1; s_start_y <= y1; s_end_x <= x2; s_end_y <= y2;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_clips.push_back(clip_segment(x1, y1, x2, y2));
        segs_sent++;
        @(negedge aclk);
        if ($urandom_range(0, 3) == 0 && gap_max > 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(negedge aclk);
        end
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (expected_clips.size() != 0) @(negedge aclk);
        repeat (TF + 12) @(negedge aclk);
    endtask

    task automatic write_window(longint l, longint r, longint b, longint t);
        longint vals[4];
        vals = '{l, r, b, t};
        for (int i = 0; i < 4; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_data <= vals[i][CB-1:0];
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
        win_l = l; win_r = r; win_b = b; win_t = t;
    endtask

    function automatic logic signed [CB-1:0] near_coord(longint lo, longint hi);
        longint v;
        case ($urandom_range(0, 5))
            0: v = $signed(12'($urandom));
            1: v = lo + $signed($urandom_range(0, 6)) - 3;
            2: v = hi + $signed($urandom_range(0, 6)) - 3;
            default: v = lo - 40 + $urandom_range(0, 80 + ((hi > lo) ? hi - lo : 0));
        endcase
        if (v > 2047) v = 2047;
        if (v < -2048) v = -2048;
        return v[CB-1:0];
    endfunction

    task automatic random_segments(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 150) == 0) gap_max = $urandom_range(0, 1) ? 0 : 6;
            send_segment(near_coord(win_l, win_r), near_coord(win_b, win_t),
                         near_coord(win_l, win_r), near_coord(win_b, win_t));
        end
    endtask

    task automatic test_directed;
        send_segment(100, 300, 200, 400);      // fully inside
        send_segment(0, 0, 10, 10);            // fully outside
        send_segment(0, 300, 400, 400);        // crosses left and right
        send_segment(100, 100, 200, 600);      // crosses bottom and top
        send_segment(-2048, -2048, 2047, 2047);
        send_segment(2047, -2048, -2048, 2047);
        send_segment(-2048, 2047, -2048, 2047);
        send_segment(40, 300, 40, 400);        // parallel outside left
        send_segment(100, 300, 100, 400);      // parallel inside
        send_segment(320, 300, 320, 400);      // parallel outside right
        send_segment(100, 240, 200, 240);      // parallel below
        send_segment(100, 510, 200, 510);      // parallel above
        send_segment(50, 250, 300, 500);       // on window corners
        send_segment(0, 600, 400, 100);        // diagonal crossing
        send_segment(0, 0, 100, 600);          // visible, enters at left and leaves at top
        send_segment(150, 350, 150, 350);      // degenerate point
        send_segment(-1, -1, 0, 0);
        drain();
    endtask

    task automatic test_windows;
        write_window(-2048, 2047, -2048, 2047);
        random_segments(300);
        drain();
        write_window(0, 0, 0, 0);
        send_segment(0, 0, 0, 0);
        send_segment(-5, 0, 5, 0);
        random_segments(100);
        drain();
        write_window(300, 50, 250, 500);      // inverted window rejects all
        random_segments(100);
        drain();
        write_window(-1000, 1000, -500, 700);
        random_segments(300);
        drain();
    endtask

    task automatic test_backpressure;
        int hold;
        write_window(-300, 400, -200, 600);
        fork
            random_segments(400);
            begin
                repeat (50) @(negedge aclk);
                hold_off = 1'b1;
                for (hold = 0; hold < 120; hold++) @(negedge aclk);
                hold_off = 1'b0;
            end
        join
        drain();
    endtask

    task automatic test_random;
        for (int ph = 0; ph < 4; ph++) begin
            longint a, b, c, d;
            a = $signed(12'($urandom)); b = $signed(12'($urandom));
            c = $signed(12'($urandom)); d = $signed(12'($urandom));
            if ($urandom_range(0, 3) != 0) begin
                if (a > b) begin longint t = a; a = b; b = t; end
                if (c > d) begin longint t = c; c = d; d = t; end
            end
            write_window(a, b, c, d);
            random_segments(180);
            drain();
        end
        write_window(50, 300, 250, 500);
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_windows();
        test_backpressure();
        test_random();
        send_segment(0, 300, 400, 400);
        drain();
        $display("%0d segments sent, %0d results checked, %0d visible, several windows",
                 segs_sent, clips_seen, visible_seen);
        if (errors == 0 && expected_clips.size() == 0) begin
            $display("line_segment_window_clip test passed");
        end else begin
            $display("line_segment_window_clip test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
